### design/pfcm_pkg.sv
// Shared types and constants for the position frame capture and mean block.
package pfcm_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_W     = 8;
    localparam int COORD_W    = 16;
    localparam int OFFSET_W   = 7;
    localparam int TOTAL_W    = 7;
    localparam int KIND_W     = 2;
    localparam int CFG_INDEX_W = 4;

    // Request kinds on the input channel
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BURST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WINDOW = 2'd2;

    // Result kinds on the output channel
    localparam logic RES_SAMPLE = 1'b0;
    localparam logic RES_MEAN   = 1'b1;

    // Framing bytes
    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h01;
    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h83;

    // Configuration register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] CFG_X_OFFSET = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_OFFSET = 4'd1;
    localparam logic [OFFSET_W-1:0]    X_OFFSET_RST = 7'd10;
    localparam logic [OFFSET_W-1:0]    Y_OFFSET_RST = 7'd12;

    // Controller to datapath commands
    typedef struct packed {
        logic byte_en;     // take a data byte
        logic sample_en;   // close the burst, record a sample
        logic window_en;   // close the window, start the dividers
        logic out_load;    // move the pending result to the output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;    // mean division finished this cycle
        logic out_free;    // output register can take a result
    } dp_status_t;

endpackage

### design/pfcm_divider.sv
// Restoring divider, one quotient bit per cycle; a zero divisor gives zero.
module pfcm_divider #(
    parameter int SUM_W = 23,
    parameter int CNT_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic [SUM_W-1:0] quotient,
    output logic             done
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  den_reg, den_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [CNT_W:0] shifted;
    logic [CNT_W:0] diff;
    logic           fits;

    // One restoring step
    always_comb begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient = (den_reg == '0) ? '0 : quo_reg;
    assign done     = done_reg;

endmodule

### design/pfcm_datapath.sv
// Datapath: offsets, frame capture, window accumulators, dividers, output register.
module pfcm_datapath #(
    parameter int SAMPLE_CAPACITY = 64,
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    input  logic [pfcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pfcm_pkg::OFFSET_W-1:0]       cfg_data,
    // request payload
    input  logic [pfcm_pkg::BYTE_W-1:0]         rx_byte,
    // controller link
    input  pfcm_pkg::ctrl_cmd_t                 cmd,
    output pfcm_pkg::dp_status_t                status,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_result_kind,
    output logic [pfcm_pkg::COORD_W-1:0]        m_x_value,
    output logic [pfcm_pkg::COORD_W-1:0]        m_y_value,
    output logic [pfcm_pkg::TOTAL_W-1:0]        m_sample_total
);

    localparam int CNT_W = $clog2(SAMPLE_CAPACITY + 1);
    localparam int SUM_W = pfcm_pkg::COORD_W + CNT_W;
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = ((POS_W > pfcm_pkg::OFFSET_W) ? POS_W : pfcm_pkg::OFFSET_W) + 1;
    localparam logic [CNT_W-1:0] CAP_VAL = CNT_W'(SAMPLE_CAPACITY);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    typedef enum logic [1:0] {
        PH_WAIT_START,
        PH_WAIT_HEADER,
        PH_NUMBER
    } phase_t;

    typedef logic [pfcm_pkg::BYTE_W-1:0] byte_t;
    typedef logic [pfcm_pkg::COORD_W-1:0] coord_t;

    // Join a big-endian pair, falling back to whichever byte was seen
    function automatic coord_t join_pair(byte_t hi, byte_t lo, logic has_hi, logic has_lo);
        coord_t val;
        if (has_hi && has_lo) begin
            val = {hi, lo};
        end else if (has_lo) begin
            val = coord_t'(lo);
        end else if (has_hi) begin
            val = coord_t'(hi);
        end else begin
            val = '0;
        end
        return val;
    endfunction

    logic [pfcm_pkg::OFFSET_W-1:0] x_off_reg, y_off_reg;

    phase_t     phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    byte_t      cap_reg [4];
    byte_t      cap_next [4];
    logic [3:0] flags_reg, flags_next;

    logic [SUM_W-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [CNT_W-1:0] cnt_x_reg, cnt_x_next, cnt_y_reg, cnt_y_next;
    logic [CNT_W-1:0] win_reg, win_next;

    logic                          res_kind_reg, res_kind_next;
    coord_t                        res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [pfcm_pkg::TOTAL_W-1:0]  res_total_reg, res_total_next;

    logic                          m_valid_reg;
    logic                          m_kind_reg;
    coord_t                        m_x_reg, m_y_reg;
    logic [pfcm_pkg::TOTAL_W-1:0]  m_total_reg;

    logic             numbering;
    logic [POS_W-1:0] pos_inc;
    logic [CMP_W-1:0] pos_cmp, pos_cmp_ahead, x_cmp, y_cmp;
    logic [3:0]       slot_hit;
    coord_t           xv, yv;
    logic [SUM_W-1:0] quo_x, quo_y;
    logic             done_x, done_y;

    // Offset registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_off_reg <= pfcm_pkg::X_OFFSET_RST;
            y_off_reg <= pfcm_pkg::Y_OFFSET_RST;
        end else if (cfg_valid) begin
            if (cfg_index == pfcm_pkg::CFG_X_OFFSET) begin
                x_off_reg <= cfg_data;
            end
            if (cfg_index == pfcm_pkg::CFG_Y_OFFSET) begin
                y_off_reg <= cfg_data;
            end
        end
    end

    // Slot matching for the current byte
    always_comb begin
        numbering     = (phase_reg == PH_NUMBER) ||
                        ((phase_reg == PH_WAIT_HEADER) && (rx_byte == pfcm_pkg::HEADER_BYTE));
        pos_inc       = pos_reg + 1'b1;
        pos_cmp       = CMP_W'(pos_inc);
        pos_cmp_ahead = pos_cmp + 1'b1;
        x_cmp         = CMP_W'(x_off_reg);
        y_cmp         = CMP_W'(y_off_reg);
        slot_hit[0]   = (pos_cmp_ahead == x_cmp);
        slot_hit[1]   = (pos_cmp == x_cmp);
        slot_hit[2]   = (pos_cmp_ahead == y_cmp);
        slot_hit[3]   = (pos_cmp == y_cmp);
        xv = join_pair(cap_reg[0], cap_reg[1], flags_reg[0], flags_reg[1]);
        yv = join_pair(cap_reg[2], cap_reg[3], flags_reg[2], flags_reg[3]);
    end

    // Framing and capture
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cap_next   = cap_reg;
        flags_next = flags_reg;
        if (cmd.byte_en) begin
            unique case (phase_reg)
                PH_WAIT_START: begin
                    if (rx_byte == pfcm_pkg::START_BYTE) begin
                        phase_next = PH_WAIT_HEADER;
                    end
                end
                PH_WAIT_HEADER: begin
                    if (rx_byte == pfcm_pkg::HEADER_BYTE) begin
                        phase_next = PH_NUMBER;
                    end
                end
                PH_NUMBER: begin
                    phase_next = PH_NUMBER;
                end
                default: begin
                    phase_next = PH_WAIT_START;
                end
            endcase
            if (numbering && (pos_reg < POS_MAX)) begin
                pos_next = pos_inc;
                for (int s = 0; s < 4; s++) begin
                    if (slot_hit[s]) begin
                        cap_next[s]   = rx_byte;
                        flags_next[s] = 1'b1;
                    end
                end
            end
        end else if (cmd.sample_en) begin
            phase_next = PH_WAIT_START;
            pos_next   = '0;
            flags_next = '0;
        end
    end

    // Window accumulators and pending result
    always_comb begin
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        cnt_x_next     = cnt_x_reg;
        cnt_y_next     = cnt_y_reg;
        win_next       = win_reg;
        res_kind_next  = res_kind_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_total_next = res_total_reg;
        if (cmd.sample_en) begin
            if (win_reg < CAP_VAL) begin
                win_next = win_reg + 1'b1;
                if (xv != '0) begin
                    sum_x_next = sum_x_reg + SUM_W'(xv);
                    cnt_x_next = cnt_x_reg + 1'b1;
                end
                if (yv != '0) begin
                    sum_y_next = sum_y_reg + SUM_W'(yv);
                    cnt_y_next = cnt_y_reg + 1'b1;
                end
            end
            res_kind_next  = pfcm_pkg::RES_SAMPLE;
            res_x_next     = xv;
            res_y_next     = yv;
            res_total_next = pfcm_pkg::TOTAL_W'(win_next);
        end else if (cmd.window_en) begin
            res_kind_next  = pfcm_pkg::RES_MEAN;
            res_total_next = pfcm_pkg::TOTAL_W'(win_reg);
            sum_x_next     = '0;
            sum_y_next     = '0;
            cnt_x_next     = '0;
            cnt_y_next     = '0;
            win_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT_START;
            pos_reg   <= '0;
            flags_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            cnt_x_reg <= '0;
            cnt_y_reg <= '0;
            win_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            cnt_x_reg <= cnt_x_next;
            cnt_y_reg <= cnt_y_next;
            win_reg   <= win_next;
        end
        cap_reg       <= cap_next;
        res_kind_reg  <= res_kind_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_total_reg <= res_total_next;
    end

    // Mean dividers, one per axis, started together
    pfcm_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.window_en),
        .dividend (sum_x_reg),
        .divisor  (cnt_x_reg),
        .quotient (quo_x),
        .done     (done_x)
    );

    pfcm_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.window_en),
        .dividend (sum_y_reg),
        .divisor  (cnt_y_reg),
        .quotient (quo_y),
        .done     (done_y)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_kind_reg  <= res_kind_reg;
            m_total_reg <= res_total_reg;
            if (res_kind_reg == pfcm_pkg::RES_MEAN) begin
                m_x_reg <= quo_x[pfcm_pkg::COORD_W-1:0];
                m_y_reg <= quo_y[pfcm_pkg::COORD_W-1:0];
            end else begin
                m_x_reg <= res_x_reg;
                m_y_reg <= res_y_reg;
            end
        end
    end

    assign status.div_done = done_x & done_y;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_x_value      = m_x_reg;
    assign m_y_value      = m_y_reg;
    assign m_sample_total = m_total_reg;

endmodule

### design/pfcm_ctrl.sv
// Controller: request decode and sequencing of divide and result hand-off.
module pfcm_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [pfcm_pkg::KIND_W-1:0]      s_kind,
    input  pfcm_pkg::dp_status_t             status,
    output pfcm_pkg::ctrl_cmd_t              cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;
    logic   take;

    // Next state and commands
    always_comb begin
        take       = s_valid && s_ready_reg;
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    unique case (s_kind)
                        pfcm_pkg::KIND_DATA: begin
                            cmd.byte_en = 1'b1;
                        end
                        pfcm_pkg::KIND_BURST: begin
                            cmd.sample_en = 1'b1;
                            state_next    = ST_EMIT;
                        end
                        pfcm_pkg::KIND_WINDOW: begin
                            cmd.window_en = 1'b1;
                            state_next    = ST_DIVIDE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

### design/position_frame_capture_and_mean.sv
// Top level: position frame capture and window mean.
//
// Input channel (s_valid/s_ready): each request carries s_kind and s_rx_byte.
//   Data bytes feed the frame capture; end of burst yields one sample
//   result; end of window yields the floor means of the nonzero samples.
// Result channel (m_valid/m_ready): one registered result per burst or
//   window request, none for data bytes or unknown kinds.
// Configuration (cfg_valid/cfg_ready): index 0 X offset, 1 Y offset;
//   always ready; the user must write it only while the block is idle (not enforced).
// Sequencing: data bytes and unknown kinds are taken back to back. An end of
//   burst moves its sample through the pending result register into the
//   output register. An end of window starts the two restoring dividers;
//   once both finish, the means are loaded into the output register. After
//   a burst or window request, the next request is taken only once its
//   result has been loaded, so a full output register stalls the input.
// A finished result waits in the output register while the next request
//   is taken; a further result is held back until the register frees.
// Reset (aresetn low, synchronous) clears framing, window sums, counts and
//   the output register and restores offsets 10 and 12.
module position_frame_capture_and_mean #(
    parameter int SAMPLE_CAPACITY = 64,
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfcm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pfcm_pkg::OFFSET_W-1:0]     cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pfcm_pkg::KIND_W-1:0]       s_kind,
    input  logic [pfcm_pkg::BYTE_W-1:0]       s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_result_kind,
    output logic [pfcm_pkg::COORD_W-1:0]      m_x_value,
    output logic [pfcm_pkg::COORD_W-1:0]      m_y_value,
    output logic [pfcm_pkg::TOTAL_W-1:0]      m_sample_total
);

    pfcm_pkg::ctrl_cmd_t  cmd;
    pfcm_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    pfcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .status  (status),
        .cmd     (cmd)
    );

    pfcm_datapath #(
        .SAMPLE_CAPACITY (SAMPLE_CAPACITY),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_byte        (s_rx_byte),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_x_value      (m_x_value),
        .m_y_value      (m_y_value),
        .m_sample_total (m_sample_total)
    );

endmodule
